// ----- hdl/nt_pkg.sv -----
// ----------------------------------------------------------------------------
// nt_pkg
// Shared sizes, codes, sequencer states and the genome record packer for the
// neighbor table with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package nt_pkg;

    localparam int NBR_SLOTS = 16;
    localparam int NBR_AW    = $clog2(NBR_SLOTS);
    localparam int NBR_CW    = $clog2(NBR_SLOTS + 1);
    localparam int GEN_SLOTS = 32;
    localparam int GEN_AW    = $clog2(GEN_SLOTS);
    localparam int GEN_CW    = $clog2(GEN_SLOTS + 1);
    localparam int HIST_LEN  = 16;
    localparam int HIST_AW   = $clog2(HIST_LEN);
    localparam int IDX_W     = (GEN_CW > NBR_CW) ? GEN_CW : NBR_CW;

    localparam int NBR_W     = 48;
    localparam int GEN_W     = 64;

    localparam logic [1:0] REQ_SWEEP   = 2'd0;
    localparam logic [1:0] REQ_MSG     = 2'd1;
    localparam logic [1:0] REQ_FITNESS = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic CFG_AGE_LIMIT = 1'b0;
    localparam logic CFG_FOOD_ID   = 1'b1;

    localparam logic [7:0] DEAD_FIT = 8'd255;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SW_RD,
        S_SW_CHK,
        S_SW_MV,
        S_NU_RD,
        S_NU_CHK,
        S_GU_RD,
        S_GU_CHK,
        S_SC_RD,
        S_SC_CHK,
        S_FIN
    } t_state;

    // hundreds, tens, ones of an 8-bit value by reciprocal multiplication
    function automatic logic [11:0] split3(input logic [7:0] v);
        logic [13:0] m;
        logic [1:0]  q;
        logic [6:0]  r;
        logic [14:0] p;
        logic [3:0]  t;
        logic [3:0]  o;
        m = 14'(v) * 14'd41;
        q = m[13:12];
        r = 7'(v - 8'(q) * 8'd100);
        p = 15'(r) * 15'd205;
        t = p[14:11];
        o = 4'(r - 7'(t) * 7'd10);
        split3 = {o, t, 2'b00, q};
        return split3;
    endfunction

    function automatic logic [63:0] pack_genome(input logic [7:0] id,
                                                input logic [7:0] a,
                                                input logic [7:0] b,
                                                input logic [7:0] c,
                                                input logic [7:0] parent,
                                                input logic [7:0] fit);
        logic [11:0] da;
        logic [11:0] db;
        logic [11:0] dc;
        da = split3(a);
        db = split3(b);
        dc = split3(c);
        pack_genome = {8'd0, fit, parent, dc[7:0], db, da, id};
        return pack_genome;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/nt_ram.sv -----
// ----------------------------------------------------------------------------
// nt_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/neighbor_table_with_aging.sv -----
// ----------------------------------------------------------------------------
// neighbor_table_with_aging
// Neighbor table with aging sweep, genome record table and food history ring.
// ----------------------------------------------------------------------------
// One item at a time. A sweep takes a read and a check step per valid
// neighbor plus a move step per dropped entry; a message takes a read and
// a check step per neighbor searched and per genome record searched; every
// item then scans the neighbor table for the food beacon, a read and a check
// step per entry. A walk that reaches its end closes with one more read step,
// and the item ends with a step to post the result. All of it is set by the
// single-port-per-direction RAM walks, which take one entry at a time. The
// result waits in an output register; the next item is taken once the block
// is back in idle.
`default_nettype none

module neighbor_table_with_aging (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic                      i_cfg_idx,
    input  wire logic [15:0]               i_cfg_data,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [1:0]                i_req_type,
    input  wire logic [31:0]               i_now_ticks,
    input  wire logic [7:0]                i_sender_id,
    input  wire logic [7:0]                i_distance,
    input  wire logic [7:0]                i_genome_word_a,
    input  wire logic [7:0]                i_genome_word_b,
    input  wire logic [7:0]                i_genome_word_c,
    input  wire logic [7:0]                i_parent_id,
    input  wire logic [7:0]                i_sender_fitness,
    input  wire logic                      i_genome_enable,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic                           o_food_present,
    output logic [4:0]                     o_neighbor_count,
    output logic [5:0]                     o_genome_count
);

    nt_pkg::t_state r_state, n_state;

    logic [15:0] r_age_limit;
    logic [7:0]  r_food_id;

    logic [1:0]  r_req;
    logic [31:0] r_now;
    logic [7:0]  r_sender, r_dist, r_wa, r_wb, r_wc, r_parent, r_fit;
    logic        r_gen_en;

    logic [nt_pkg::IDX_W-1:0]  r_k, n_k;
    logic [nt_pkg::NBR_CW-1:0] r_nbr_total, n_nbr_total;
    logic [nt_pkg::GEN_CW-1:0] r_gen_total, n_gen_total;
    logic                      r_found, n_found;

    logic [nt_pkg::HIST_LEN-1:0] r_hist;
    logic [nt_pkg::HIST_AW-1:0]  r_hptr;

    logic                        r_out_valid, r_food_out;
    logic [4:0]                  r_nbr_out;
    logic [5:0]                  r_gen_out;

    logic                        nbr_we;
    logic [nt_pkg::NBR_AW-1:0]   nbr_waddr, nbr_raddr;
    logic [nt_pkg::NBR_W-1:0]    nbr_wdata, nbr_rd;
    logic                        gen_we;
    logic [nt_pkg::GEN_AW-1:0]   gen_waddr, gen_raddr;
    logic [nt_pkg::GEN_W-1:0]    gen_wdata, gen_rd;

    logic accept, gen_go, stale, nbr_end, gen_end, out_free;
    logic [nt_pkg::IDX_W-1:0] k_dec;

    assign o_ready  = (r_state == nt_pkg::S_IDLE);
    assign accept   = i_valid && o_ready;
    assign gen_go   = r_gen_en && (r_sender != r_food_id) && (r_fit != nt_pkg::DEAD_FIT);
    assign stale    = (r_now - nbr_rd[39:8]) > {16'd0, r_age_limit};
    assign nbr_end  = (r_k == nt_pkg::IDX_W'(r_nbr_total));
    assign gen_end  = (r_k == nt_pkg::IDX_W'(r_gen_total));
    assign out_free = !r_out_valid || i_ready;
    assign k_dec    = r_k - 1'b1;

    nt_ram #(.DEPTH(nt_pkg::NBR_SLOTS), .WIDTH(nt_pkg::NBR_W)) u_nbr_ram (
        .i_clk   (i_clk),
        .i_we    (nbr_we),
        .i_waddr (nbr_waddr),
        .i_wdata (nbr_wdata),
        .i_raddr (nbr_raddr),
        .o_rdata (nbr_rd)
    );

    nt_ram #(.DEPTH(nt_pkg::GEN_SLOTS), .WIDTH(nt_pkg::GEN_W)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            nt_pkg::S_IDLE: begin
                if (i_valid) begin
                    case (i_req_type)
                        nt_pkg::REQ_SWEEP: n_state = nt_pkg::S_SW_RD;
                        nt_pkg::REQ_MSG:   n_state = nt_pkg::S_NU_RD;
                        default:           n_state = nt_pkg::S_SC_RD;
                    endcase
                end
            end
            nt_pkg::S_SW_RD:  n_state = (r_k == '0) ? nt_pkg::S_SC_RD : nt_pkg::S_SW_CHK;
            nt_pkg::S_SW_CHK: n_state = stale ? nt_pkg::S_SW_MV : nt_pkg::S_SW_RD;
            nt_pkg::S_SW_MV:  n_state = nt_pkg::S_SW_RD;
            nt_pkg::S_NU_RD: begin
                if (nbr_end) begin
                    n_state = gen_go ? nt_pkg::S_GU_RD : nt_pkg::S_SC_RD;
                end else begin
                    n_state = nt_pkg::S_NU_CHK;
                end
            end
            nt_pkg::S_NU_CHK: begin
                if (nbr_rd[47:40] == r_sender) begin
                    n_state = gen_go ? nt_pkg::S_GU_RD : nt_pkg::S_SC_RD;
                end else begin
                    n_state = nt_pkg::S_NU_RD;
                end
            end
            nt_pkg::S_GU_RD:  n_state = gen_end ? nt_pkg::S_SC_RD : nt_pkg::S_GU_CHK;
            nt_pkg::S_GU_CHK: begin
                n_state = (gen_rd[7:0] == r_sender) ? nt_pkg::S_SC_RD : nt_pkg::S_GU_RD;
            end
            nt_pkg::S_SC_RD:  n_state = nbr_end ? nt_pkg::S_FIN : nt_pkg::S_SC_CHK;
            nt_pkg::S_SC_CHK: n_state = nt_pkg::S_SC_RD;
            nt_pkg::S_FIN:    n_state = out_free ? nt_pkg::S_IDLE : nt_pkg::S_FIN;
            default:          n_state = nt_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_k         = r_k;
        n_nbr_total = r_nbr_total;
        n_gen_total = r_gen_total;
        n_found     = r_found;
        nbr_we      = 1'b0;
        nbr_waddr   = r_k[nt_pkg::NBR_AW-1:0];
        nbr_wdata   = {r_sender, r_now, r_dist};
        nbr_raddr   = r_k[nt_pkg::NBR_AW-1:0];
        gen_we      = 1'b0;
        gen_waddr   = r_k[nt_pkg::GEN_AW-1:0];
        gen_wdata   = nt_pkg::pack_genome(r_sender, r_wa, r_wb, r_wc, r_parent, r_fit);
        gen_raddr   = r_k[nt_pkg::GEN_AW-1:0];
        case (r_state)
            nt_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_found = 1'b0;
                    n_k = (i_req_type == nt_pkg::REQ_SWEEP) ?
                          nt_pkg::IDX_W'(r_nbr_total) : '0;
                end
            end
            nt_pkg::S_SW_RD: begin
                nbr_raddr = k_dec[nt_pkg::NBR_AW-1:0];
            end
            nt_pkg::S_SW_CHK: begin
                n_k = k_dec;
                nbr_raddr = nt_pkg::NBR_AW'(r_nbr_total - 1'b1);
            end
            nt_pkg::S_SW_MV: begin
                nbr_we      = 1'b1;
                nbr_wdata   = nbr_rd;
                n_nbr_total = r_nbr_total - 1'b1;
            end
            nt_pkg::S_NU_RD: begin
                if (nbr_end) begin
                    nbr_we = 1'b1;
                    n_k    = '0;
                    if (r_nbr_total < nt_pkg::NBR_CW'(nt_pkg::NBR_SLOTS)) begin
                        nbr_waddr   = r_nbr_total[nt_pkg::NBR_AW-1:0];
                        n_nbr_total = r_nbr_total + 1'b1;
                    end else begin
                        nbr_waddr = nt_pkg::NBR_AW'(nt_pkg::NBR_SLOTS - 1);
                    end
                end
            end
            nt_pkg::S_NU_CHK: begin
                if (nbr_rd[47:40] == r_sender) begin
                    nbr_we = 1'b1;
                    n_k    = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            nt_pkg::S_GU_RD: begin
                if (gen_end) begin
                    gen_we = 1'b1;
                    n_k    = '0;
                    if (r_gen_total < nt_pkg::GEN_CW'(nt_pkg::GEN_SLOTS)) begin
                        gen_waddr   = r_gen_total[nt_pkg::GEN_AW-1:0];
                        n_gen_total = r_gen_total + 1'b1;
                    end else begin
                        gen_waddr = nt_pkg::GEN_AW'(nt_pkg::GEN_SLOTS - 1);
                    end
                end
            end
            nt_pkg::S_GU_CHK: begin
                if (gen_rd[7:0] == r_sender) begin
                    gen_we = 1'b1;
                    n_k    = '0;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            nt_pkg::S_SC_CHK: begin
                if (nbr_rd[47:40] == r_food_id) begin
                    n_found = 1'b1;
                end
                n_k = r_k + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nt_pkg::S_IDLE;
            r_age_limit <= 16'd32;
            r_food_id   <= 8'd0;
            r_k         <= '0;
            r_nbr_total <= '0;
            r_gen_total <= '0;
            r_found     <= 1'b0;
            r_hist      <= '0;
            r_hptr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_nbr_total <= n_nbr_total;
            r_gen_total <= n_gen_total;
            r_found     <= n_found;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    nt_pkg::CFG_AGE_LIMIT: r_age_limit <= i_cfg_data;
                    nt_pkg::CFG_FOOD_ID:   r_food_id   <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == nt_pkg::S_FIN && out_free) begin
                r_out_valid <= 1'b1;
                if (r_req == nt_pkg::REQ_FITNESS) begin
                    r_hist[r_hptr] <= r_found;
                    r_hptr <= (r_hptr == nt_pkg::HIST_AW'(nt_pkg::HIST_LEN - 1)) ?
                              '0 : r_hptr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req_type;
            r_now    <= i_now_ticks;
            r_sender <= i_sender_id;
            r_dist   <= i_distance;
            r_wa     <= i_genome_word_a;
            r_wb     <= i_genome_word_b;
            r_wc     <= i_genome_word_c;
            r_parent <= i_parent_id;
            r_fit    <= i_sender_fitness;
            r_gen_en <= i_genome_enable;
        end
        if (r_state == nt_pkg::S_FIN && out_free) begin
            r_food_out <= r_found;
            r_nbr_out  <= 5'(r_nbr_total);
            r_gen_out  <= 6'(r_gen_total);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_food_present   = r_food_out;
    assign o_neighbor_count = r_nbr_out;
    assign o_genome_count   = r_gen_out;

endmodule

`default_nettype wire
